[src/dtq_pkg.sv]
// Shared constants and types for the deadline timer queue.
// Depends on nothing; imported by the top level.
package dtq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam int TIME_W = 48;
   localparam int ID_W   = 31;
   localparam int DLY_W  = 31;
   localparam int TAG_W  = 16;
   localparam int WAIT_W = 32;
   localparam int MODE_W = 2;
   localparam int KIND_W = 3;

   localparam int REQ_DATA_W = 176;
   localparam int RSP_DATA_W = 128;

   localparam logic [ID_W-1:0]   ID_MAX   = {ID_W{1'b1}};
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_POLL   = 2'd2,
      MODE_NONE   = 2'd3
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADDED    = 3'd0,
      KIND_FULL     = 3'd1,
      KIND_REMOVED  = 3'd2,
      KIND_EXPIRED  = 3'd3,
      KIND_NEXTWAIT = 3'd4
   } kind_type;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [ID_W-1:0]   ident;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

[src/dtq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/deadline_timer_queue_unit.sv]
// Deadline timer queue top level: control sequencer, valid bits and id counter.
// Depends on dtq_pkg and dtq_ram (entry store).
//
// Holds up to CAPACITY pending timeouts in one RAM; validity lives in flip-flops that
// reset clears, so the unit is ready straight after reset. Every add, remove and poll
// sweeps the whole table through the RAM read port, one entry per cycle. A poll sweeps
// again after each timeout it expires, since each expiry needs a fresh sweep for the
// next-earliest entry. An unused mode is taken from idle and gives no item. The result
// register lets a new request in while the last item of the previous one still waits on
// rsp_tready.
module deadline_timer_queue_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode
   input  logic [dtq_pkg::MODE_W-1:0]        req_tuser,
   // current_time, delay_ms, handler_tag, ref_deadline, ref_id, zero pad
   input  logic [dtq_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // result_kind
   output logic [dtq_pkg::KIND_W-1:0]        rsp_tuser,
   // entry_id, deadline, tag_out, wait_ms, found
   output logic [dtq_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);

   import dtq_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DONE
   } state_type;

   state_type         state_ff, state_in;
   mode_type          mode_ff, mode_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] key_dl_ff, key_dl_in;
   logic [ID_W-1:0]   key_id_ff, key_id_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [ID_W-1:0]   id_counter_ff, id_counter_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;

   logic [IDX_W-1:0]  scan_ff, scan_in;
   logic              pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]  pipe_idx_ff, pipe_idx_in;

   logic              hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   logic              best_vld_ff, best_vld_in;
   entry_type         best_ff, best_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0]     rsp_dl_ff, rsp_dl_in;
   logic [TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [WAIT_W-1:0]     rsp_wait_ff, rsp_wait_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   entry_type         ram_wr_data;
   entry_type         rd_entry;
   logic [ENTRY_W-1:0] rd_raw;

   logic [TIME_W-1:0] req_time;
   logic [DLY_W-1:0]  req_delay;
   logic [TAG_W-1:0]  req_tag;
   logic [TIME_W-1:0] req_rdl;
   logic [ID_W-1:0]   req_rid;
   logic [TIME_W:0]   dl_sum;
   logic [ID_W-1:0]   next_id;

   logic              out_free;
   logic              key_match;
   logic              rd_less;
   logic              free_any;
   logic [IDX_W-1:0]  free_idx;
   logic [TIME_W:0]   diff;
   logic [WAIT_W-1:0] wait_val;

   assign req_time  = req_tdata[TIME_W-1:0];
   assign req_delay = req_tdata[TIME_W+DLY_W-1:TIME_W];
   assign req_tag   = req_tdata[TIME_W+DLY_W+TAG_W-1:TIME_W+DLY_W];
   assign req_rdl   = req_tdata[2*TIME_W+DLY_W+TAG_W-1:TIME_W+DLY_W+TAG_W];
   assign req_rid   = req_tdata[2*TIME_W+DLY_W+TAG_W+ID_W-1:2*TIME_W+DLY_W+TAG_W];

   assign dl_sum  = {1'b0, req_time} + {{(TIME_W+1-DLY_W){1'b0}}, req_delay};
   assign next_id = (id_counter_ff == ID_MAX) ? ID_W'(1) : id_counter_ff + ID_W'(1);

   dtq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_ff),
      .rd_data (rd_raw)
   );

   assign rd_entry = entry_type'(rd_raw);

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign key_match = (rd_entry.deadline == key_dl_ff) && (rd_entry.ident == key_id_ff);
   assign rd_less   = (rd_entry.deadline < best_ff.deadline) ||
                      ((rd_entry.deadline == best_ff.deadline) &&
                       (rd_entry.ident < best_ff.ident));

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign diff = {1'b0, best_ff.deadline} - {1'b0, now_ff};
   assign wait_val = (diff[TIME_W-1:ID_W] != '0) ? {1'b0, ID_MAX}
                                                 : {1'b0, diff[ID_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      now_in        = now_ff;
      key_dl_in     = key_dl_ff;
      key_id_in     = key_id_ff;
      tag_in        = tag_ff;
      id_counter_in = id_counter_ff;
      valid_in      = valid_ff;
      scan_in       = scan_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = scan_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      best_vld_in   = best_vld_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_found_in = rsp_found_ff;
      rsp_last_in  = rsp_last_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = free_idx;
      ram_wr_data = '{deadline: key_dl_ff, ident: key_id_ff, tag: tag_ff};

      // compare stage: entry read in the previous cycle
      if (pipe_vld_ff && valid_ff[pipe_idx_ff]) begin
         if (mode_ff == MODE_POLL) begin
            if (!best_vld_ff || rd_less) begin
               best_vld_in = 1'b1;
               best_in     = rd_entry;
               best_idx_in = pipe_idx_ff;
            end
         end else if (key_match) begin
            hit_in     = 1'b1;
            hit_idx_in = pipe_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in     = mode_type'(req_tuser);
               now_in      = req_time;
               tag_in      = req_tag;
               hit_in      = 1'b0;
               best_vld_in = 1'b0;
               scan_in     = '0;
               if (mode_type'(req_tuser) == MODE_ADD) begin
                  key_dl_in = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
                  key_id_in = next_id;
               end else begin
                  key_dl_in = req_rdl;
                  key_id_in = req_rid;
               end
               if (mode_type'(req_tuser) != MODE_NONE) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            pipe_vld_in = 1'b1;
            pipe_idx_in = scan_ff;
            if (scan_ff == IDX_W'(CAPACITY - 1)) begin
               state_in = ST_LAST;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ADDED;
               rsp_id_in    = '0;
               rsp_dl_in    = '0;
               rsp_tag_in   = '0;
               rsp_wait_in  = '0;
               rsp_found_in = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               case (mode_ff)
                  MODE_ADD: begin
                     if (hit_ff || free_any) begin
                        id_counter_in = key_id_ff;
                        rsp_id_in     = key_id_ff;
                        rsp_dl_in     = key_dl_ff;
                        if (!hit_ff) begin
                           ram_wr_en          = 1'b1;
                           valid_in[free_idx] = 1'b1;
                        end
                     end else begin
                        rsp_kind_in = KIND_FULL;
                     end
                  end
                  MODE_REMOVE: begin
                     rsp_kind_in  = KIND_REMOVED;
                     rsp_found_in = hit_ff;
                     if (hit_ff) begin
                        valid_in[hit_idx_ff] = 1'b0;
                     end
                  end
                  default: begin
                     if (best_vld_ff && diff[TIME_W]) begin
                        // expire the earliest entry, then sweep again
                        rsp_kind_in             = KIND_EXPIRED;
                        rsp_id_in               = best_ff.ident;
                        rsp_dl_in               = best_ff.deadline;
                        rsp_tag_in              = best_ff.tag;
                        rsp_last_in             = 1'b0;
                        valid_in[best_idx_ff]   = 1'b0;
                        best_vld_in             = 1'b0;
                        scan_in                 = '0;
                        state_in                = ST_SCAN;
                     end else begin
                        rsp_kind_in = KIND_NEXTWAIT;
                        rsp_wait_in = best_vld_ff ? wait_val : {WAIT_W{1'b1}};
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         id_counter_ff <= '0;
         valid_ff      <= '0;
         pipe_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_ff       <= '0;
         hit_ff        <= 1'b0;
         best_vld_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         id_counter_ff <= id_counter_in;
         valid_ff      <= valid_in;
         pipe_vld_ff   <= pipe_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         scan_ff       <= scan_in;
         hit_ff        <= hit_in;
         best_vld_ff   <= best_vld_in;
      end
      mode_ff      <= mode_in;
      now_ff       <= now_in;
      key_dl_ff    <= key_dl_in;
      key_id_ff    <= key_id_in;
      tag_ff       <= tag_in;
      pipe_idx_ff  <= pipe_idx_in;
      hit_idx_ff   <= hit_idx_in;
      best_ff      <= best_in;
      best_idx_ff  <= best_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_dl_ff    <= rsp_dl_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_found_ff <= rsp_found_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {rsp_found_ff, rsp_wait_ff, rsp_tag_ff, rsp_dl_ff, rsp_id_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[sim/tb.sv]
// Self-checking bench for deadline_timer_queue_unit: a directed table, then random
// add/remove/poll traffic, checked item by item against the table or a predictor.
// Depends on dtq_pkg and the deadline_timer_queue_unit RTL.
`timescale 1ns / 100ps

module tb;
   import dtq_pkg::*;

   localparam int LIMIT     = 1000000;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE    = 400;

   typedef struct packed {
      mode_type           mode;
      logic [TIME_W-1:0]  now;
      logic [DLY_W-1:0]   delay;
      logic [TAG_W-1:0]   tag;
      logic [TIME_W-1:0]  rdl;
      logic [ID_W-1:0]    rid;
   } req_item_type;

   typedef struct packed {
      kind_type                  kind;
      logic [ID_W-1:0]           ident;
      logic [TIME_W-1:0]         deadline;
      logic [TAG_W-1:0]          tag;
      logic signed [WAIT_W-1:0]  wait_ms;
      logic                      found;
      logic                      last;
   } timer_result_type;

   typedef struct packed {
      req_item_type      item;
      logic [4:0]        copies;
      logic              typed;
      timer_result_type  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [MODE_W-1:0] req_tuser = '0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [KIND_W-1:0] rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   logic tx_idle = 1'b0;
   logic rx_idle = 1'b0;
   logic long_hold_req = 1'b0;

   logic              slot_busy [CAPACITY];
   logic [TIME_W-1:0] slot_deadline [CAPACITY];
   logic [ID_W-1:0]   slot_ident [CAPACITY];
   logic [TAG_W-1:0]  slot_tag [CAPACITY];
   logic [ID_W-1:0]   ident_count = '0;

   timer_result_type pending_results [$];
   int mismatches = 0;
   int cycle_count = 0;

   stim_row_type directed_rows [21] = '{
      '{'{MODE_POLL, 48'd0, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b1,
        '{KIND_NEXTWAIT, 31'd0, 48'd0, 16'd0, -32'sd1, 1'b0, 1'b1}},
      '{'{MODE_REMOVE, 48'd0, 31'd0, 16'd0, 48'd0, 31'd1}, 5'd1, 1'b1,
        '{KIND_REMOVED, 31'd0, 48'd0, 16'd0, 32'sd0, 1'b0, 1'b1}},
      '{'{MODE_ADD, 48'd0, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b1,
        '{KIND_ADDED, 31'd1, 48'd0, 16'd0, 32'sd0, 1'b0, 1'b1}},
      '{'{MODE_ADD, TIME_MAX, ID_MAX, 16'hFFFF, 48'd0, 31'd0}, 5'd1, 1'b1,
        '{KIND_ADDED, 31'd2, TIME_MAX, 16'd0, 32'sd0, 1'b0, 1'b1}},
      '{'{MODE_ADD, 48'd1000, 31'd0, 16'hA5A5, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_POLL, 48'd0, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_ADD, 48'd1000, 31'd0, 16'h5A5A, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_POLL, 48'd1000, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_POLL, 48'd1001, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_REMOVE, 48'd0, 31'd0, 16'd0, TIME_MAX, 31'd2}, 5'd1, 1'b1,
        '{KIND_REMOVED, 31'd0, 48'd0, 16'd0, 32'sd0, 1'b1, 1'b1}},
      '{'{MODE_REMOVE, 48'd0, 31'd0, 16'd0, TIME_MAX, 31'd2}, 5'd1, 1'b1,
        '{KIND_REMOVED, 31'd0, 48'd0, 16'd0, 32'sd0, 1'b0, 1'b1}},
      '{'{MODE_NONE, TIME_MAX, ID_MAX, 16'hFFFF, TIME_MAX, ID_MAX}, 5'd1, 1'b0, '0},
      '{'{MODE_ADD, 48'd0, ID_MAX, 16'h0F0F, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_POLL, 48'd0, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_POLL, 48'd1, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_REMOVE, 48'd0, 31'd0, 16'd0, 48'h7FFFFFFF, 31'd5}, 5'd1, 1'b1,
        '{KIND_REMOVED, 31'd0, 48'd0, 16'd0, 32'sd0, 1'b1, 1'b1}},
      '{'{MODE_ADD, 48'd100, 31'd50, 16'h1234, 48'd0, 31'd0}, 5'd16, 1'b0, '0},
      '{'{MODE_ADD, 48'd100, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b1,
        '{KIND_FULL, 31'd0, 48'd0, 16'd0, 32'sd0, 1'b0, 1'b1}},
      '{'{MODE_REMOVE, 48'd0, 31'd0, 16'd0, TIME_MAX, ID_MAX}, 5'd1, 1'b1,
        '{KIND_REMOVED, 31'd0, 48'd0, 16'd0, 32'sd0, 1'b0, 1'b1}},
      '{'{MODE_POLL, TIME_MAX, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b0, '0},
      '{'{MODE_POLL, TIME_MAX, 31'd0, 16'd0, 48'd0, 31'd0}, 5'd1, 1'b1,
        '{KIND_NEXTWAIT, 31'd0, 48'd0, 16'd0, -32'sd1, 1'b0, 1'b1}}
   };

   deadline_timer_queue_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic timer_result_type result_of(kind_type k, logic [ID_W-1:0] id,
                                                  logic [TIME_W-1:0] dl, logic [TAG_W-1:0] tg,
                                                  logic signed [WAIT_W-1:0] w, logic f,
                                                  logic l);
      timer_result_type r;
      r.kind = k;
      r.ident = id;
      r.deadline = dl;
      r.tag = tg;
      r.wait_ms = w;
      r.found = f;
      r.last = l;
      return r;
   endfunction

   function automatic int key_slot(logic [TIME_W-1:0] dl, logic [ID_W-1:0] id);
      for (int i = 0; i < CAPACITY; i++) begin
         if (slot_busy[i] && slot_deadline[i] == dl && slot_ident[i] == id) return i;
      end
      return -1;
   endfunction

   function automatic int earliest_slot();
      int best;
      best = -1;
      for (int i = 0; i < CAPACITY; i++) begin
         if (slot_busy[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
             (slot_deadline[i] == slot_deadline[best] && slot_ident[i] < slot_ident[best])))
            best = i;
      end
      return best;
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      logic [63:0] wide;
      wide = {$urandom, $urandom};
      return wide[TIME_W-1:0];
   endfunction

   // advance the timeout table by one item and queue what it should give
   task automatic predict_timer_results(input req_item_type it, input logic typed,
                                        input timer_result_type typed_res);
      timer_result_type produced [$];
      logic [TIME_W:0] sum;
      logic [TIME_W-1:0] dl;
      logic [TIME_W-1:0] gap;
      logic [ID_W-1:0] next_id;
      logic signed [WAIT_W-1:0] wait_v;
      int slot;
      int m;
      logic done;
      case (it.mode)
         MODE_ADD: begin
            sum = {1'b0, it.now} + {{(TIME_W-DLY_W+1){1'b0}}, it.delay};
            dl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            next_id = (ident_count == ID_MAX) ? ID_W'(1) : ident_count + ID_W'(1);
            if (key_slot(dl, next_id) >= 0) begin
               ident_count = next_id;
               produced.push_back(result_of(KIND_ADDED, next_id, dl, '0, '0, 1'b0, 1'b1));
            end else begin
               slot = -1;
               for (int i = CAPACITY - 1; i >= 0; i--) if (!slot_busy[i]) slot = i;
               if (slot < 0) begin
                  produced.push_back(result_of(KIND_FULL, '0, '0, '0, '0, 1'b0, 1'b1));
               end else begin
                  ident_count = next_id;
                  slot_busy[slot] = 1'b1;
                  slot_deadline[slot] = dl;
                  slot_ident[slot] = next_id;
                  slot_tag[slot] = it.tag;
                  produced.push_back(result_of(KIND_ADDED, next_id, dl, '0, '0, 1'b0, 1'b1));
               end
            end
         end
         MODE_REMOVE: begin
            slot = key_slot(it.rdl, it.rid);
            if (slot >= 0) slot_busy[slot] = 1'b0;
            produced.push_back(result_of(KIND_REMOVED, '0, '0, '0, '0, slot >= 0, 1'b1));
         end
         MODE_POLL: begin
            done = 1'b0;
            m = -1;
            while (!done) begin
               m = earliest_slot();
               if (m < 0 || !(slot_deadline[m] < it.now)) begin
                  done = 1'b1;
               end else begin
                  slot_busy[m] = 1'b0;
                  produced.push_back(result_of(KIND_EXPIRED, slot_ident[m], slot_deadline[m],
                                               slot_tag[m], '0, 1'b0, 1'b0));
               end
            end
            if (m < 0) begin
               wait_v = -32'sd1;
            end else begin
               gap = slot_deadline[m] - it.now;
               wait_v = (gap > TIME_W'(ID_MAX)) ? 32'sh7FFFFFFF : $signed(gap[WAIT_W-1:0]);
            end
            produced.push_back(result_of(KIND_NEXTWAIT, '0, '0, '0, wait_v, 1'b0, 1'b1));
         end
         default: ;
      endcase
      if (typed) pending_results.push_back(typed_res);
      else foreach (produced[i]) pending_results.push_back(produced[i]);
   endtask

   task automatic send_request(input req_item_type it, input logic typed,
                               input timer_result_type typed_res);
      req_tvalid <= 1'b1;
      req_tuser <= it.mode;
      req_tdata <= {2'b00, it.rid, it.rdl, it.tag, it.delay, it.now};
      do @(posedge clock); while (!req_tready);
      predict_timer_results(it, typed, typed_res);
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   initial begin : stimulus
      stim_row_type row;
      req_item_type it;
      int useful;
      int pick;
      int n;
      int busy [$];
      logic fill;
      logic [TIME_W-1:0] sim_now;
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         for (int c = 0; c < int'(row.copies); c++) send_request(row.item, row.typed, row.want);
      end

      useful = 0;
      sim_now = 48'd5000;
      while (useful < 215) begin
         if (useful % 40 == 0) begin
            tx_idle <= (useful < 180) && ($urandom_range(0, 1) == 1);
            rx_idle <= (useful < 180) && ($urandom_range(0, 1) == 1);
         end
         if (useful == 60) long_hold_req <= 1'b1;
         if (useful == 130) drain_results();
         fill = (useful >= 150 && useful < 190);
         pick = $urandom_range(0, 99);
         it.mode = MODE_ADD;
         it.now = sim_now;
         it.delay = DLY_W'($urandom);
         it.tag = TAG_W'($urandom);
         it.rdl = rand_time();
         it.rid = ID_W'($urandom);
         if (pick < 5) begin
            it.mode = MODE_NONE;
         end else if (pick < 10) begin
            it.mode = (pick < 8) ? MODE_POLL : MODE_ADD;
            it.now = rand_time();
         end else if (pick < (fill ? 80 : 50)) begin
            if ($urandom_range(0, 9) != 0)
               it.delay = fill ? DLY_W'($urandom_range(200, 2000)) : DLY_W'($urandom_range(0, 300));
         end else if (pick < (fill ? 90 : 75)) begin
            it.mode = MODE_REMOVE;
            busy.delete();
            foreach (slot_busy[i]) if (slot_busy[i]) busy.push_back(i);
            if (busy.size() != 0 && $urandom_range(0, 3) != 0) begin
               n = busy[$urandom_range(0, busy.size() - 1)];
               it.rdl = slot_deadline[n];
               it.rid = slot_ident[n];
               if ($urandom_range(0, 7) == 0) it.rid = it.rid ^ ID_W'(1);
            end
         end else begin
            it.mode = MODE_POLL;
            sim_now = sim_now + TIME_W'($urandom_range(0, 200));
            it.now = sim_now;
         end
         send_request(it, 1'b0, '0);
         if (it.mode != MODE_NONE) useful++;
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : result_pacing
      int stall;
      logic held;
      stall = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req && !held) begin
            held = 1'b1;
            stall = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
         end else if (rx_idle && $urandom_range(0, 3) == 0) begin
            stall = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      timer_result_type want;
      logic signed [WAIT_W-1:0] got_wait;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_wait = $signed(rsp_tdata[126:95]);
         if (pending_results.size() == 0) begin
            $display("%0t unexpected item: kind %0d id %0d deadline %0d", $time,
                     rsp_tuser, rsp_tdata[30:0], rsp_tdata[78:31]);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.kind || rsp_tdata[30:0] !== want.ident ||
                rsp_tdata[78:31] !== want.deadline || rsp_tdata[94:79] !== want.tag ||
                got_wait !== want.wait_ms || rsp_tdata[127] !== want.found ||
                rsp_tlast !== want.last) begin
               $display("%0t mismatch: expected kind %0d id %0d dl %0d tag %h wait %0d",
                        $time, want.kind, want.ident, want.deadline, want.tag, want.wait_ms,
                        " found %0d last %0d,", want.found, want.last,
                        " actual kind %0d id %0d dl %0d tag %h wait %0d",
                        rsp_tuser, rsp_tdata[30:0], rsp_tdata[78:31], rsp_tdata[94:79],
                        got_wait, " found %0d last %0d", rsp_tdata[127], rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
